### rtl/g2p_pkg.sv
// Shared types, constants and calendar helper functions for the date converter.
package g2p_pkg;

  typedef struct packed {
    logic [11:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
  } g2p_in_t;

  typedef struct packed {
    logic        date_ok;
    logic [10:0] pers_year;
    logic [3:0]  pers_month;
    logic [4:0]  pers_day;
  } g2p_out_t;

  typedef struct packed {
    logic load;
    logic gstep;
    logic gfix;
    logic pstep;
    logic emit;
  } g2p_cmd_t;

  typedef struct packed {
    logic gw_done;
    logic pw_done;
    logic out_free;
  } g2p_sts_t;

  localparam logic [11:0] GREG_YEAR_MIN    = 12'd1900;
  localparam logic [11:0] GREG_YEAR_MAX    = 12'd2399;
  localparam logic [11:0] GREG_ANCHOR_YEAR = 12'd2016;
  // residues of the anchor year mod 4, 100 and 400
  localparam logic [1:0]  ANCHOR_R4        = 2'd0;
  localparam logic [6:0]  ANCHOR_R100      = 7'd16;
  localparam logic [8:0]  ANCHOR_R400      = 9'd16;

  localparam logic [10:0] PERS_ANCHOR_YEAR  = 11'd1394;
  localparam logic [3:0]  PERS_ANCHOR_MONTH = 4'd10;
  localparam logic [5:0]  PERS_ANCHOR_DAY   = 6'd11;

  localparam logic [9:0]  YEAR_DAYS  = 10'd365;
  localparam logic [17:0] YEAR_STEP  = 18'd365;
  localparam logic [17:0] MONTH_STEP = 18'd29;
  localparam logic [3:0]  LAST_MONTH = 4'd12;

  function automatic logic [4:0] greg_month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m) inside
      4'd2:                        len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
      [4'd1:4'd12]:                len = 5'd31;
      default:                     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] greg_cum(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // floor(x*3100/128) mod 100 == floor(25*((31*x) mod 128)/32), so only
  // the low seven bits of x matter.
  function automatic logic [6:0] pers_frac(input logic [6:0] x);
    logic [11:0] p;
    logic [11:0] f;
    p = {5'd0, x} * 12'd31;
    f = 12'd25 * {5'd0, p[6:0]};
    return f[11:5];
  endfunction

  function automatic logic pers_leap(input logic [10:0] y);
    logic [6:0] a;
    logic [6:0] b;
    a = pers_frac(y[6:0] + 7'd37);
    b = pers_frac(y[6:0] + 7'd38);
    return (a >= 7'd31) && (b < 7'd31);
  endfunction

  function automatic logic [5:0] pers_dim(input logic [3:0] m, input logic leap);
    logic [5:0] len;
    case (m) inside
      [4'd1:4'd6]:  len = 6'd31;
      [4'd7:4'd11]: len = 6'd30;
      default:      len = leap ? 6'd30 : 6'd29;
    endcase
    return len;
  endfunction

endpackage

### rtl/gregorian_to_persian_date_unit.sv
// Top level of the Gregorian to Persian date converter.
//
//   channel | ports                      | payload
//   --------+----------------------------+------------------------------------
//   input   | in_valid / in_ready        | in_data  : greg_year/month/day
//   result  | out_valid / out_ready      | out_data : date_ok, pers_year/month/day
//
// Steps per item: accept, Gregorian year walk (one year per cycle from 2016
//   toward greg_year), day-offset fixup, Persian walk (one 365-, 29- or 1-day
//   step per cycle until the day offset is used up), then write to the output
//   register.
// Out-of-range years end the year walk at once; an invalid date still passes
//   through the fixup and the Persian walk state.
// Reset is synchronous, active low; it clears the sequencer and output valid.
// A finished item waits for a free output register; a new item can be taken
// while a previous result still waits on out_ready.
module gregorian_to_persian_date_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  g2p_pkg::g2p_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output g2p_pkg::g2p_out_t out_data
);
  import g2p_pkg::*;

  // command and status between the sequencer and the datapath
  g2p_cmd_t cmd;
  g2p_sts_t sts;

  g2p_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  g2p_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/g2p_ctrl.sv
// Sequencer for the converter: load, Gregorian year walk, fixup, Persian walk, emit.
module g2p_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  g2p_pkg::g2p_sts_t sts,
  output g2p_pkg::g2p_cmd_t cmd
);
  import g2p_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_GWALK = 5'b00010,
    ST_GFIX  = 5'b00100,
    ST_PWALK = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_GWALK;
        end
      end
      ST_GWALK: begin
        cmd.gstep = 1'b1;
        if (sts.gw_done) state_nxt = ST_GFIX;
      end
      ST_GFIX: begin
        cmd.gfix  = 1'b1;
        state_nxt = ST_PWALK;
      end
      ST_PWALK: begin
        cmd.pstep = 1'b1;
        if (sts.pw_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_GWALK))
    else $error("accepted item did not start the year walk");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !sts.out_free) |=> (state_r == ST_FIN))
    else $error("finished item dropped while output busy");

endmodule

### rtl/g2p_datapath.sv
// Datapath: Gregorian day count, Persian date stepper and output register.
module g2p_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  g2p_pkg::g2p_in_t   in_data,
  input  g2p_pkg::g2p_cmd_t  cmd,
  output g2p_pkg::g2p_sts_t  sts,
  output logic               out_valid,
  input  logic               out_ready,
  output g2p_pkg::g2p_out_t  out_data
);
  import g2p_pkg::*;

  // latched input
  logic [11:0]        gy_r, gy_nxt;
  logic [3:0]         gm_r, gm_nxt;
  logic [4:0]         gd_r, gd_nxt;
  // Gregorian year walk
  logic [11:0]        yc_r, yc_nxt;
  logic [1:0]         r4_r, r4_nxt, r4_dn, r4_up;
  logic [6:0]         r100_r, r100_nxt, r100_dn, r100_up;
  logic [8:0]         r400_r, r400_nxt, r400_dn, r400_up;
  logic signed [18:0] gn_r, gn_nxt;
  logic               leap_cur, leap_dn;
  logic [9:0]         ydays_cur, ydays_dn;
  logic               range_ok;
  // fixup
  logic [4:0]         mlen;
  logic               adj;
  logic signed [18:0] nfin;
  logic [18:0]        nabs;
  logic               ok_r, ok_nxt;
  logic               fwd_r, fwd_nxt;
  // Persian walk
  logic [17:0]        nm_r, nm_nxt, nm_stp;
  logic [10:0]        py_r, py_nxt, py_stp;
  logic [3:0]         pm_r, pm_nxt, pm_stp;
  logic [5:0]         pd_r, pd_nxt, pd_stp;
  logic               leap_y, leap_ym1;
  logic [5:0]         len;
  // output
  logic               out_valid_r, out_valid_nxt;
  g2p_out_t           out_data_r, out_data_nxt;

  assign range_ok = (gy_r >= GREG_YEAR_MIN) && (gy_r <= GREG_YEAR_MAX);

  // residues of yc+1 and yc-1
  assign r4_up   = r4_r + 2'd1;
  assign r4_dn   = r4_r - 2'd1;
  assign r100_up = (r100_r == 7'd99)  ? 7'd0   : r100_r + 7'd1;
  assign r100_dn = (r100_r == 7'd0)   ? 7'd99  : r100_r - 7'd1;
  assign r400_up = (r400_r == 9'd399) ? 9'd0   : r400_r + 9'd1;
  assign r400_dn = (r400_r == 9'd0)   ? 9'd399 : r400_r - 9'd1;

  assign leap_cur  = ((r4_r == 2'd0) && (r100_r != 7'd0)) || (r400_r == 9'd0);
  assign leap_dn   = ((r4_dn == 2'd0) && (r100_dn != 7'd0)) || (r400_dn == 9'd0);
  assign ydays_cur = YEAR_DAYS + {9'd0, leap_cur};
  assign ydays_dn  = YEAR_DAYS + {9'd0, leap_dn};

  // fixup: month offset, day, and Feb 29 correction
  assign mlen = greg_month_len(gm_r) + {4'd0, (gm_r == 4'd2) && leap_cur};
  assign adj  = (gm_r > 4'd2) && leap_cur;
  assign nfin = gn_r + $signed({10'd0, greg_cum(gm_r)}) + $signed({14'd0, gd_r})
              - 19'sd1 + $signed({18'd0, adj});
  assign nabs = (nfin > 19'sd0) ? nfin : -nfin;

  assign sts.gw_done  = (yc_r == gy_r) || !range_ok;
  assign sts.pw_done  = !ok_r || (nm_r == 18'd0);
  assign sts.out_free = !out_valid_r || out_ready;

  // one Persian walk step
  always_comb begin
    leap_y   = pers_leap(py_r);
    leap_ym1 = pers_leap(py_r - 11'd1);
    py_stp   = py_r;
    pm_stp   = pm_r;
    pd_stp   = pd_r;
    nm_stp   = nm_r;
    len      = 6'd0;
    if (fwd_r) begin
      if (nm_r >= YEAR_STEP) begin
        if (leap_y) begin
          if (pd_r > 6'd1) begin
            pd_stp = pd_r - 6'd1;
          end else if (pm_r > 4'd1) begin
            pm_stp = pm_r - 4'd1;
            pd_stp = pers_dim(pm_r - 4'd1, leap_y);
          end else begin
            py_stp = py_r - 11'd1;
            pm_stp = LAST_MONTH;
            pd_stp = leap_ym1 ? 6'd30 : 6'd29;
          end
        end
        py_stp = py_stp + 11'd1;
        nm_stp = nm_r - YEAR_STEP;
      end else if (nm_r >= MONTH_STEP) begin
        len    = pers_dim(pm_r, leap_y);
        nm_stp = nm_r - MONTH_STEP;
        pd_stp = pd_r + 6'd29;
        if (pd_stp > len) begin
          if (pm_r >= LAST_MONTH) begin
            py_stp = py_r + 11'd1;
            pm_stp = 4'd1;
          end else begin
            pm_stp = pm_r + 4'd1;
          end
          pd_stp = pd_stp - len;
        end
      end else begin
        if (pd_r < pers_dim(pm_r, leap_y)) begin
          pd_stp = pd_r + 6'd1;
        end else if (pm_r < LAST_MONTH) begin
          pm_stp = pm_r + 4'd1;
          pd_stp = 6'd1;
        end else begin
          py_stp = py_r + 11'd1;
          pm_stp = 4'd1;
          pd_stp = 6'd1;
        end
        nm_stp = nm_r - 18'd1;
      end
    end else begin
      if (nm_r >= YEAR_STEP) begin
        if (leap_ym1) begin
          if (pd_r < pers_dim(pm_r, leap_y)) begin
            pd_stp = pd_r + 6'd1;
          end else if (pm_r < LAST_MONTH) begin
            pm_stp = pm_r + 4'd1;
            pd_stp = 6'd1;
          end else begin
            py_stp = py_r + 11'd1;
            pm_stp = 4'd1;
            pd_stp = 6'd1;
          end
        end
        py_stp = py_stp - 11'd1;
        nm_stp = nm_r - YEAR_STEP;
      end else if (nm_r >= MONTH_STEP) begin
        len    = (pm_r <= 4'd1) ? pers_dim(LAST_MONTH, leap_ym1)
                                : pers_dim(pm_r - 4'd1, leap_y);
        nm_stp = nm_r - MONTH_STEP;
        if (pd_r > 6'd29) begin
          pd_stp = pd_r - 6'd29;
        end else begin
          if (pm_r <= 4'd1) begin
            py_stp = py_r - 11'd1;
            pm_stp = LAST_MONTH;
          end else begin
            pm_stp = pm_r - 4'd1;
          end
          pd_stp = pd_r + len - 6'd29;
        end
      end else begin
        if (pd_r > 6'd1) begin
          pd_stp = pd_r - 6'd1;
        end else if (pm_r > 4'd1) begin
          pm_stp = pm_r - 4'd1;
          pd_stp = pers_dim(pm_r - 4'd1, leap_y);
        end else begin
          py_stp = py_r - 11'd1;
          pm_stp = LAST_MONTH;
          pd_stp = leap_ym1 ? 6'd30 : 6'd29;
        end
        nm_stp = nm_r - 18'd1;
      end
    end
  end

  always_comb begin
    gy_nxt        = gy_r;
    gm_nxt        = gm_r;
    gd_nxt        = gd_r;
    yc_nxt        = yc_r;
    r4_nxt        = r4_r;
    r100_nxt      = r100_r;
    r400_nxt      = r400_r;
    gn_nxt        = gn_r;
    ok_nxt        = ok_r;
    fwd_nxt       = fwd_r;
    nm_nxt        = nm_r;
    py_nxt        = py_r;
    pm_nxt        = pm_r;
    pd_nxt        = pd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (cmd.load) begin
      gy_nxt   = in_data.greg_year;
      gm_nxt   = in_data.greg_month;
      gd_nxt   = in_data.greg_day;
      yc_nxt   = GREG_ANCHOR_YEAR;
      r4_nxt   = ANCHOR_R4;
      r100_nxt = ANCHOR_R100;
      r400_nxt = ANCHOR_R400;
      gn_nxt   = 19'sd0;
      py_nxt   = PERS_ANCHOR_YEAR;
      pm_nxt   = PERS_ANCHOR_MONTH;
      pd_nxt   = PERS_ANCHOR_DAY;
    end
    if (cmd.gstep && !sts.gw_done) begin
      if (gy_r > yc_r) begin
        gn_nxt   = gn_r + $signed({9'd0, ydays_cur});
        yc_nxt   = yc_r + 12'd1;
        r4_nxt   = r4_up;
        r100_nxt = r100_up;
        r400_nxt = r400_up;
      end else begin
        gn_nxt   = gn_r - $signed({9'd0, ydays_dn});
        yc_nxt   = yc_r - 12'd1;
        r4_nxt   = r4_dn;
        r100_nxt = r100_dn;
        r400_nxt = r400_dn;
      end
    end
    if (cmd.gfix) begin
      ok_nxt  = range_ok && (gm_r >= 4'd1) && (gm_r <= LAST_MONTH)
             && (gd_r != 5'd0) && (gd_r <= mlen);
      fwd_nxt = (nfin > 19'sd0);
      nm_nxt  = nabs[17:0];
    end
    if (cmd.pstep && !sts.pw_done) begin
      py_nxt = py_stp;
      pm_nxt = pm_stp;
      pd_nxt = pd_stp;
      nm_nxt = nm_stp;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (ok_r) begin
        out_data_nxt.date_ok    = 1'b1;
        out_data_nxt.pers_year  = py_r;
        out_data_nxt.pers_month = pm_r;
        out_data_nxt.pers_day   = pd_r[4:0];
      end else begin
        out_data_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gy_r       <= gy_nxt;
    gm_r       <= gm_nxt;
    gd_r       <= gd_nxt;
    yc_r       <= yc_nxt;
    r4_r       <= r4_nxt;
    r100_r     <= r100_nxt;
    r400_r     <= r400_nxt;
    gn_r       <= gn_nxt;
    ok_r       <= ok_nxt;
    fwd_r      <= fwd_nxt;
    nm_r       <= nm_nxt;
    py_r       <= py_nxt;
    pm_r       <= pm_nxt;
    pd_r       <= pd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken item");

  a_walk_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pstep && !sts.pw_done) |=> (nm_r < $past(nm_r)))
    else $error("Persian walk made no progress");

  a_out_date: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && ok_r) |=> (out_data_r.pers_month != 4'd0
                            && out_data_r.pers_month <= LAST_MONTH
                            && out_data_r.pers_day != 5'd0))
    else $error("converted date out of range");

endmodule

### tb/testbench.sv
// Testbench for gregorian_to_persian_date_unit: random and directed dates checked against a built-in calendar model.
`timescale 1ns / 1ps

module testbench;
  import g2p_pkg::*;

  // Cycles with no item moving on either channel before the run is abandoned.
  // The limit is far above the slowest item and the long receiver
  // hold-off, so this leaves a wide margin.
  localparam int IDLE_LIMIT    = 30000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT_COUNT = 150;
  localparam int TAIL_CYCLES   = 900;
  localparam int RANDOM_ITEMS  = 500;

  typedef struct {
    g2p_in_t date;
    bit      wait_drain;  // sender holds this item back until all results are in
  } pending_date_t;

  typedef struct {
    g2p_in_t  src;
    g2p_out_t res;
  } persian_entry_t;

  typedef struct {
    int unsigned y;
    int unsigned m;
    int unsigned d;
  } solar_date_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  g2p_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  g2p_out_t out_data;

  pending_date_t  dates_to_send[$];
  persian_entry_t persian_due[$];
  persian_entry_t due_now;

  int sent_count = 0;   // items accepted on the input channel (driver only)
  int seen_count = 0;   // results accepted on the output channel (nonblocking)
  int errors     = 0;

  // sender burst shaping
  int burst_left = 1;
  int gap_left   = 0;

  // receiver stall pattern
  int mon_cycle  = 0;
  int ready_mode = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  int idle_cycles = 0;

  gregorian_to_persian_date_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Calendar model
  // ---------------------------------------------------------------------

  function automatic bit greg_is_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned greg_month_days(int unsigned y, int unsigned m);
    case (m)
      2:            return greg_is_leap(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic int unsigned greg_days_before(int unsigned m);
    case (m)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      default: return 334;
    endcase
  endfunction

  // 1-based day number counted from the proleptic start of the calendar
  function automatic int unsigned greg_day_number(int unsigned y, int unsigned m,
                                                  int unsigned d);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400 + greg_days_before(m) + d;
    if (m > 2 && greg_is_leap(y)) n++;
    return n;
  endfunction

  // 128-year arithmetic rule, exact in integers
  function automatic int unsigned solar_frac(int unsigned x);
    return ((x * 3100) / 128) % 100;
  endfunction

  function automatic bit solar_is_leap(int unsigned y);
    return solar_frac(y + 37) >= 31 && solar_frac(y + 38) < 31;
  endfunction

  function automatic int unsigned solar_month_days(int unsigned y, int unsigned m);
    int unsigned i;
    i = (m - 1) % 12;
    if (i < 6) return 31;
    if (i < 11) return 30;
    return solar_is_leap(y) ? 30 : 29;
  endfunction

  function automatic solar_date_t solar_prev_day(solar_date_t s);
    if (s.d > 1) begin
      s.d--;
    end else if (s.m > 1) begin
      s.m--;
      s.d = solar_month_days(s.y, s.m);
    end else begin
      s.y--;
      s.m = 12;
      s.d = solar_is_leap(s.y) ? 30 : 29;
    end
    return s;
  endfunction

  function automatic solar_date_t solar_next_day(solar_date_t s);
    if (s.d < solar_month_days(s.y, s.m)) begin
      s.d++;
    end else if (s.m < 12) begin
      s.m++;
      s.d = 1;
    end else begin
      s.y++;
      s.m = 1;
      s.d = 1;
    end
    return s;
  endfunction

  // Persian date for one Gregorian input; all zero for an invalid date.
  // Walks from 1394-10-11 (= 2016-01-01) in 365-, 29- and 1-day steps.
  function automatic g2p_out_t persian_of(g2p_in_t date);
    int unsigned gy, gm, gd, len, py, pm;
    int          n;
    solar_date_t s;
    g2p_out_t    r;
    gy = date.greg_year;
    gm = date.greg_month;
    gd = date.greg_day;
    r  = '0;
    if (gy < 1900 || gy > 2399 || gm < 1 || gm > 12 || gd < 1 ||
        gd > greg_month_days(gy, gm))
      return r;
    s = '{y: 1394, m: 10, d: 11};
    n = int'(greg_day_number(gy, gm, gd)) - int'(greg_day_number(2016, 1, 1));
    if (n > 0) begin
      while (n > 0) begin
        if (n >= 365) begin
          if (solar_is_leap(s.y)) s = solar_prev_day(s);
          s.y++;
          n -= 365;
        end else if (n >= 29) begin
          len = solar_month_days(s.y, s.m);
          n -= 29;
          s.d += 29;
          if (s.d > len) begin
            s.m++;
            if (s.m > 12) begin
              s.y++;
              s.m = 1;
            end
            s.d -= len;
          end
        end else begin
          s = solar_next_day(s);
          n -= 1;
        end
      end
    end else begin
      n = -n;
      while (n > 0) begin
        if (n >= 365) begin
          if (solar_is_leap(s.y - 1)) s = solar_next_day(s);
          s.y--;
          n -= 365;
        end else if (n >= 29) begin
          if (s.m <= 1) begin
            py = s.y - 1;
            pm = 12;
          end else begin
            py = s.y;
            pm = s.m - 1;
          end
          len = solar_month_days(py, pm);
          n -= 29;
          if (s.d > 29) begin
            s.d -= 29;
          end else begin
            if (s.m <= 1) begin
              s.y--;
              s.m = 12;
            end else begin
              s.m--;
            end
            s.d += len - 29;
          end
        end else begin
          s = solar_prev_day(s);
          n -= 1;
        end
      end
    end
    r.date_ok    = 1'b1;
    r.pers_year  = 11'(s.y);
    r.pers_month = 4'(s.m);
    r.pers_day   = 5'(s.d);
    return r;
  endfunction

  function automatic void add_date(int unsigned y, int unsigned m, int unsigned d,
                                   bit drain = 1'b0);
    pending_date_t p;
    p.date.greg_year  = 12'(y);
    p.date.greg_month = 4'(m);
    p.date.greg_day   = 5'(d);
    p.wait_drain      = drain;
    dates_to_send.push_back(p);
  endfunction

  task automatic check_field(input string field, input logic [10:0] want,
                             input logic [10:0] got, input g2p_in_t src);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch for %0d-%0d-%0d: expected %0d, actual %0d", $time,
               field, src.greg_year, src.greg_month, src.greg_day, want, got);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued dates in bursts with random gaps. An item marked
  // wait_drain is held back until every accepted item has its result back.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        persian_due.push_back('{src: in_data, res: persian_of(in_data)});
        sent_count++;
      end
      // the channel is free when nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (dates_to_send.size() != 0 &&
                     !(dates_to_send[0].wait_drain && sent_count != seen_count)) begin
          in_data  <= dates_to_send[0].date;
          in_valid <= 1'b1;
          void'(dates_to_send.pop_front());
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            // a quarter of the bursts run straight into the next one
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks every result against the oldest expectation, and drives
  // out_ready from a stall pattern in one of four modes picked at random. Once,
  // after HOLD_AT_COUNT results, ready is held low for a long hold-off so the
  // block backs up and drops in_ready while the sender keeps offering.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (persian_due.size() == 0) begin
          errors++;
          $display("%0t: result with no pending date: expected none, actual %0d %0d-%0d-%0d",
                   $time, out_data.date_ok, out_data.pers_year, out_data.pers_month,
                   out_data.pers_day);
        end else begin
          due_now = persian_due.pop_front();
          check_field("date_ok", 11'(due_now.res.date_ok), 11'(out_data.date_ok),
                      due_now.src);
          check_field("pers_year", due_now.res.pers_year, out_data.pers_year, due_now.src);
          check_field("pers_month", 11'(due_now.res.pers_month), 11'(out_data.pers_month),
                      due_now.src);
          check_field("pers_day", 11'(due_now.res.pers_day), 11'(out_data.pers_day),
                      due_now.src);
        end
        seen_count <= seen_count + 1;
      end

      mon_cycle++;
      if (mon_cycle % 64 == 0) ready_mode = $urandom_range(0, 3);

      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && seen_count >= HOLD_AT_COUNT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        case (ready_mode)
          0:       out_ready <= 1'b1;                         // no stalls
          1:       out_ready <= ($urandom_range(0, 3) != 0);  // light stalls
          2:       out_ready <= ($urandom_range(0, 3) == 0);  // heavy stalls
          default: out_ready <= mon_cycle[0];                 // alternating ready and stall
        endcase
      end
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int unsigned y, m, d, dim, pick;

    // directed: anchor and its neighbors, Persian new year, range ends,
    // Gregorian leap rule by 4 / 100 / 400, bad months, bad days, bad years
    add_date(2016, 1, 1);
    add_date(2015, 12, 31);
    add_date(2016, 3, 20);
    add_date(2016, 3, 21);
    add_date(1900, 1, 1);
    add_date(2399, 12, 31);
    add_date(2000, 2, 29);
    add_date(1900, 2, 29);
    add_date(2100, 2, 28);
    add_date(2100, 2, 29);
    add_date(2024, 2, 29);
    add_date(2023, 2, 29);
    add_date(2023, 4, 31);
    add_date(2023, 1, 31);
    add_date(2023, 0, 10);
    add_date(2023, 13, 5);
    add_date(2023, 15, 31);
    add_date(2023, 6, 0);
    add_date(1899, 12, 31);
    add_date(2400, 1, 1);
    add_date(4095, 15, 31);
    add_date(0, 0, 0);
    add_date(2025, 3, 20);
    add_date(2025, 3, 21);

    // random: mostly well-formed dates, many near the anchor to keep the
    // walks short, some day overflows, the rest raw noise on every bit
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        y   = $urandom_range(0, 1) ? $urandom_range(1990, 2045) : $urandom_range(1900, 2399);
        m   = $urandom_range(1, 12);
        dim = greg_month_days(y, m);
        case ($urandom_range(0, 3))
          0:       d = 1;
          1:       d = dim;
          default: d = $urandom_range(1, dim);
        endcase
      end else if (pick < 75) begin
        y   = $urandom_range(1900, 2399);
        m   = $urandom_range(1, 12);
        dim = greg_month_days(y, m);
        d   = (dim < 31) ? $urandom_range(dim + 1, 31) : 0;
      end else begin
        y = $urandom_range(0, 4095);
        m = $urandom_range(0, 15);
        d = $urandom_range(0, 31);
      end
      // two points where the sender waits for the block to run dry
      add_date(y, m, d, k == 0 || k == RANDOM_ITEMS / 2);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // sampled away from the active edge so the outcome is order independent
    do @(negedge clk);
    while (dates_to_send.size() != 0 || in_valid || sent_count != seen_count);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (persian_due.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, persian_due.size());
    if (errors == 0 && persian_due.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
